[rtl/srug_pkg.sv]
package srug_pkg;

    // Pattern modes; the unused code falls back to the plain circle
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SPIRAL  = 2'd1;
    localparam logic [1:0] MODE_INVERSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam int RADIUS_W = 24;
    localparam int COUNT_W  = 7;
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int PART_W   = 32;

    // Both dividers run over the same numerator width so they line up
    localparam int DIV_NUM_W = 39;

    // CORDIC datapath widths
    localparam int CX_W = 34;
    localparam int CZ_W = 33;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd65536;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 7'd1;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-k) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

[rtl/srug_div.sv]
module srug_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    // Restoring division, one quotient bit per stage. Quotient bits shift
    // into the numerator register from the bottom as numerator bits leave.
    logic [NUM_W-1:0] r_num [1:NUM_W];
    logic [DEN_W-1:0] r_rem [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [NUM_W-1:0] s_num;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [DEN_W:0]   s_trial;
        logic [DEN_W:0]   s_diff;
        logic             s_ge;

        if (g == 0) begin : g_first
            assign s_num = i_num;
            assign s_rem = '0;
            assign s_den = i_den;
        end else begin : g_next
            assign s_num = r_num[g];
            assign s_rem = r_rem[g];
            assign s_den = r_den[g];
        end

        assign s_trial = {s_rem, s_num[NUM_W-1]};
        assign s_diff  = s_trial - {1'b0, s_den};
        assign s_ge    = s_trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            r_num[g+1] <= {s_num[NUM_W-2:0], s_ge};
            r_rem[g+1] <= s_ge ? s_diff[DEN_W-1:0] : s_trial[DEN_W-1:0];
            r_den[g+1] <= s_den;
        end
    end

    assign o_quo = r_num[NUM_W];

endmodule

[rtl/scaled_root_of_unity_gen_top.sv]
// Scaled root-of-unity generator.
// Pulse start with point_index i (taken when busy is low; busy never rises,
// so a new index may enter on every clock). The block returns point i of
// point_count points spaced evenly around a circle, angle 2*pi*i/n, scaled
// by radius (normal), radius/(i+1) (spiral) or (i+1)/radius (inverse
// spiral). Parts are signed Q16.16, saturated; o_saturated flags a clip.
// Configuration: write radius, point count and mode through the cfg channel
// (valid/ready, ready always high) while no point is in flight.
// Pipeline: DIV_NUM_W (39) stages of bit-serial pipelined division, then
// CORDIC_STEPS rotation stages, then quadrant/abs, multiply, round and
// saturate stages.
// Throughput: one beat per cycle.
// Each result beat shows on the outputs for one cycle with o_valid high;
// the receiver cannot stall, so nothing is held back.
// Reset clears all in-flight beats and restores radius 1.0, one point and
// normal mode; no memory needs clearing.
module scaled_root_of_unity_gen_top #(
    parameter int MAX_POINTS   = 64,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [srug_pkg::INDEX_W-1:0]   i_point_index,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [srug_pkg::RADIUS_W-1:0]  i_cfg_data,
    output logic                           o_valid,
    output logic [srug_pkg::PART_W-1:0]    o_real_part,
    output logic [srug_pkg::PART_W-1:0]    o_imag_part,
    output logic                           o_saturated
);
    import srug_pkg::*;

    localparam int CLAMP_N = (MAX_POINTS < 127) ? MAX_POINTS : 127;
    localparam int LAT     = DIV_NUM_W + CORDIC_STEPS + 3;

    // ---------------- configuration ----------------
    logic [RADIUS_W-1:0] r_radius;
    logic [COUNT_W-1:0]  r_point_count;
    logic [MODE_W-1:0]   r_pattern_mode;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= RADIUS_RST;
            r_point_count  <= COUNT_RST;
            r_pattern_mode <= MODE_NORMAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius       <= i_cfg_data;
                CFG_COUNT:  r_point_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_MODE:   r_pattern_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    logic r_vld [1:LAT];
    logic accept;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= LAT; j++) r_vld[j] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld[1] <= accept;
            for (int j = 2; j <= LAT; j++) r_vld[j] <= r_vld[j-1];
            o_valid <= r_vld[LAT];
        end
    end

    // ---------------- divider operands ----------------
    logic [COUNT_W-1:0]   cnt_eff;
    logic [COUNT_W-1:0]   ip1;
    logic [RADIUS_W-1:0]  inv_den;
    logic [DIV_NUM_W-1:0] ph_num;
    logic [DIV_NUM_W-1:0] mg_num;
    logic [RADIUS_W-1:0]  mg_den;
    logic [DIV_NUM_W-1:0] ph_quo;
    logic [DIV_NUM_W-1:0] mg_quo;

    always_comb begin
        // zero points acts as one; clamp to the supported maximum
        if (r_point_count == '0)
            cnt_eff = COUNT_W'(1);
        else if (32'(r_point_count) > CLAMP_N)
            cnt_eff = COUNT_W'(CLAMP_N);
        else
            cnt_eff = r_point_count;

        ip1     = {1'b0, i_point_index} + COUNT_W'(1);
        // zero radius divides by one LSB instead
        inv_den = (r_radius == '0) ? RADIUS_W'(1) : r_radius;

        ph_num = DIV_NUM_W'({i_point_index, 32'b0}) + DIV_NUM_W'(cnt_eff[COUNT_W-1:1]);

        if (r_pattern_mode == MODE_INVERSE) begin
            mg_num = DIV_NUM_W'({ip1, 32'b0}) + DIV_NUM_W'(inv_den[RADIUS_W-1:1]);
            mg_den = inv_den;
        end else begin
            mg_num = DIV_NUM_W'(r_radius) + DIV_NUM_W'(ip1[COUNT_W-1:1]);
            mg_den = RADIUS_W'(ip1);
        end
    end

    srug_div #(.NUM_W(DIV_NUM_W), .DEN_W(COUNT_W)) u_phase_div (
        .i_clk (i_clk),
        .i_num (ph_num),
        .i_den (cnt_eff),
        .o_quo (ph_quo)
    );

    srug_div #(.NUM_W(DIV_NUM_W), .DEN_W(RADIUS_W)) u_mag_div (
        .i_clk (i_clk),
        .i_num (mg_num),
        .i_den (mg_den),
        .o_quo (mg_quo)
    );

    // magnitude: divider result for spiral modes, the radius otherwise
    logic [DIV_NUM_W-1:0] mag_sel;
    assign mag_sel = (r_pattern_mode == MODE_SPIRAL || r_pattern_mode == MODE_INVERSE)
                   ? mg_quo : DIV_NUM_W'(r_radius);

    // ---------------- CORDIC rotation pipeline ----------------
    logic signed [CX_W-1:0] r_cx [1:CORDIC_STEPS];
    logic signed [CX_W-1:0] r_cy [1:CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_cz [1:CORDIC_STEPS];
    logic [1:0]             r_cq [1:CORDIC_STEPS];
    logic [DIV_NUM_W-1:0]   r_cm [1:CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        logic signed [CX_W-1:0] s_x;
        logic signed [CX_W-1:0] s_y;
        logic signed [CZ_W-1:0] s_z;
        logic [1:0]             s_q;
        logic [DIV_NUM_W-1:0]   s_m;
        logic signed [CZ_W-1:0] s_at;
        logic                   s_up;

        if (g == 0) begin : g_first
            assign s_x = CORDIC_GAIN;
            assign s_y = '0;
            assign s_z = $signed({3'b000, ph_quo[29:0]});
            assign s_q = ph_quo[31:30];
            assign s_m = mag_sel;
        end else begin : g_next
            assign s_x = r_cx[g];
            assign s_y = r_cy[g];
            assign s_z = r_cz[g];
            assign s_q = r_cq[g];
            assign s_m = r_cm[g];
        end

        assign s_at = $signed({1'b0, ATAN_TURNS[g]});
        assign s_up = ~s_z[CZ_W-1];

        always_ff @(posedge i_clk) begin
            r_cx[g+1] <= s_up ? s_x - (s_y >>> g) : s_x + (s_y >>> g);
            r_cy[g+1] <= s_up ? s_y + (s_x >>> g) : s_y - (s_x >>> g);
            r_cz[g+1] <= s_up ? s_z - s_at : s_z + s_at;
            r_cq[g+1] <= s_q;
            r_cm[g+1] <= s_m;
        end
    end

    // ---------------- quadrant map and magnitude split ----------------
    logic signed [CX_W-1:0] re_c;
    logic signed [CX_W-1:0] im_c;
    logic signed [CX_W-1:0] re_abs;
    logic signed [CX_W-1:0] im_abs;

    always_comb begin
        case (r_cq[CORDIC_STEPS])
            2'd0: begin
                re_c = r_cx[CORDIC_STEPS];
                im_c = r_cy[CORDIC_STEPS];
            end
            2'd1: begin
                re_c = -r_cy[CORDIC_STEPS];
                im_c = r_cx[CORDIC_STEPS];
            end
            2'd2: begin
                re_c = -r_cx[CORDIC_STEPS];
                im_c = -r_cy[CORDIC_STEPS];
            end
            default: begin
                re_c = r_cy[CORDIC_STEPS];
                im_c = -r_cx[CORDIC_STEPS];
            end
        endcase
        re_abs = re_c[CX_W-1] ? -re_c : re_c;
        im_abs = im_c[CX_W-1] ? -im_c : im_c;
    end

    logic [31:0] r_re_mag, r_im_mag;
    logic        r_re_neg, r_im_neg;
    logic [6:0]  r_mh;
    logic [31:0] r_ml;

    always_ff @(posedge i_clk) begin
        r_re_mag <= re_abs[31:0];
        r_im_mag <= im_abs[31:0];
        r_re_neg <= re_c[CX_W-1];
        r_im_neg <= im_c[CX_W-1];
        r_mh     <= r_cm[CORDIC_STEPS][DIV_NUM_W-1:32];
        r_ml     <= r_cm[CORDIC_STEPS][31:0];
    end

    // ---------------- multiply ----------------
    logic [38:0] r_re_hi, r_im_hi;
    logic [63:0] r_re_lo, r_im_lo;
    logic        r_re_neg2, r_im_neg2;

    always_ff @(posedge i_clk) begin
        r_re_hi   <= 39'(r_mh) * 39'(r_re_mag);
        r_im_hi   <= 39'(r_mh) * 39'(r_im_mag);
        r_re_lo   <= 64'(r_ml) * 64'(r_re_mag);
        r_im_lo   <= 64'(r_ml) * 64'(r_im_mag);
        r_re_neg2 <= r_re_neg;
        r_im_neg2 <= r_im_neg;
    end

    // ---------------- round and combine partial products ----------------
    logic [41:0] re_sum, im_sum;
    logic [64:0] re_rnd, im_rnd;
    logic [41:0] r_re_sum, r_im_sum;
    logic        r_re_neg3, r_im_neg3;

    always_comb begin
        re_rnd = 65'(r_re_lo) + 65'(33'h20000000);
        im_rnd = 65'(r_im_lo) + 65'(33'h20000000);
        re_sum = 42'({r_re_hi, 2'b00}) + 42'(re_rnd[64:30]);
        im_sum = 42'({r_im_hi, 2'b00}) + 42'(im_rnd[64:30]);
    end

    always_ff @(posedge i_clk) begin
        r_re_sum  <= re_sum;
        r_im_sum  <= im_sum;
        r_re_neg3 <= r_re_neg2;
        r_im_neg3 <= r_im_neg2;
    end

    // ---------------- saturate, drive outputs ----------------
    logic [31:0] re_out, im_out;
    logic        re_sat, im_sat;

    always_comb begin
        if (r_re_neg3) begin
            re_sat = r_re_sum > 42'h080000000;
            re_out = re_sat ? 32'h80000000 : 32'(42'd0 - r_re_sum);
        end else begin
            re_sat = r_re_sum > 42'h07FFFFFFF;
            re_out = re_sat ? 32'h7FFFFFFF : r_re_sum[31:0];
        end

        if (r_im_neg3) begin
            im_sat = r_im_sum > 42'h080000000;
            im_out = im_sat ? 32'h80000000 : 32'(42'd0 - r_im_sum);
        end else begin
            im_sat = r_im_sum > 42'h07FFFFFFF;
            im_out = im_sat ? 32'h7FFFFFFF : r_im_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_real_part <= re_out;
        o_imag_part <= im_out;
        o_saturated <= re_sat | im_sat;
    end

endmodule

[tb/scaled_root_of_unity_gen_top_test.sv]
`timescale 1ns / 100ps

module scaled_root_of_unity_gen_top_test;
    import srug_pkg::*;

    localparam int POINT_LIMIT = 64;
    localparam int ROTATIONS   = 18;
    // Pipeline depth from the top-level header plus slack
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [PART_W-1:0] re_part;
        logic [PART_W-1:0] im_part;
        logic              clipped;
    } point_t;

    typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

    // One directed beat: a register write or a point request. Typed fields
    // override the predicted ones where the answer is obvious.
    typedef struct packed {
        row_kind_t           kind;
        logic [1:0]          reg_idx;
        logic [RADIUS_W-1:0] value;
        logic                has_re;
        logic [PART_W-1:0]   re_part;
        logic                has_clip;
        logic                clipped;
    } row_t;

    localparam row_t DIRECTED_ROWS [27] = '{
        // reset settings: one point, unit radius, normal mode
        '{ROW_POINT, 2'd0, 24'd0,  1'b0, 32'd0, 1'b0, 1'b0},
        // index past the count keeps turning
        '{ROW_POINT, 2'd0, 24'd63, 1'b0, 32'd0, 1'b0, 1'b0},
        // four points: one per quadrant
        '{ROW_CFG,   CFG_COUNT, 24'd4, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd0,  1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd1,  1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd2,  1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd3,  1'b0, 32'd0, 1'b0, 1'b0},
        // largest radius
        '{ROW_CFG,   CFG_RADIUS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd1,  1'b0, 32'd0, 1'b0, 1'b0},
        // zero radius in normal mode collapses to the origin
        '{ROW_CFG,   CFG_RADIUS, 24'd0, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd1,  1'b1, 32'd0, 1'b1, 1'b0},
        // inverse spiral with the smallest radius clips high
        '{ROW_CFG,   CFG_RADIUS, 24'd1, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE, {22'd0, MODE_INVERSE}, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd0,  1'b1, 32'h7FFFFFFF, 1'b1, 1'b1},
        // inverse spiral with zero radius divides by one LSB
        '{ROW_CFG,   CFG_RADIUS, 24'd0, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd0,  1'b1, 32'h7FFFFFFF, 1'b1, 1'b1},
        // unused mode code falls back to the plain circle
        '{ROW_CFG,   CFG_RADIUS, 24'h010000, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE, 24'd3, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd2,  1'b0, 32'd0, 1'b0, 1'b0},
        // spiral at the far end
        '{ROW_CFG,   CFG_MODE, {22'd0, MODE_SPIRAL}, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_RADIUS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd63, 1'b0, 32'd0, 1'b0, 1'b0},
        // zero count acts as one, oversize count clamps
        '{ROW_CFG,   CFG_COUNT, 24'd0,   1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd5,  1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_COUNT, 24'd127, 1'b0, 32'd0, 1'b0, 1'b0},
        '{ROW_POINT, 2'd0, 24'd33, 1'b0, 32'd0, 1'b0, 1'b0},
        // write to an index past the register list is dropped
        '{ROW_CFG,   2'd3, 24'hABCDEF, 1'b0, 32'd0, 1'b0, 1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [INDEX_W-1:0]  i_point_index = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [RADIUS_W-1:0] i_cfg_data = '0;
    logic                o_valid;
    logic [PART_W-1:0]   o_real_part;
    logic [PART_W-1:0]   o_imag_part;
    logic                o_saturated;

    // Mirror of the block's registers
    logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
    logic [COUNT_W-1:0]  count_q  = COUNT_RST;
    logic [MODE_W-1:0]   mode_q   = MODE_NORMAL;

    // Typed answers travel with the request beat
    logic              typed_has_re = 1'b0;
    logic [PART_W-1:0] typed_re = '0;
    logic              typed_has_clip = 1'b0;
    logic              typed_clip = 1'b0;

    point_t pending_points [$];
    int     mismatch_count = 0;

    scaled_root_of_unity_gen_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_point_index (i_point_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_real_part   (o_real_part),
        .o_imag_part   (o_imag_part),
        .o_saturated   (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Scale a Q1.30 component by magnitude m (units of 2^-16), round half
    // away from zero, clip to signed 32 bits.
    function automatic logic [PART_W-1:0] scale_component(
        input logic [63:0] m, input longint comp, inout logic clip);
        logic        neg;
        logic [63:0] c, mh, ml, mag;
        neg = comp < 0;
        c   = neg ? 64'(-comp) : 64'(comp);
        mh  = m >> 32;
        ml  = {32'd0, m[31:0]};
        if (mh > 64'hFFFF) mh = 64'hFFFF;
        mag = ((mh * c) << 2) + ((ml * c + (64'd1 << 29)) >> 30);
        if (neg) begin
            if (mag > 64'h80000000) begin
                clip = 1'b1;
                mag  = 64'h80000000;
            end
            return PART_W'(64'd0 - mag);
        end
        if (mag > 64'h7FFFFFFF) begin
            clip = 1'b1;
            mag  = 64'h7FFFFFFF;
        end
        return mag[PART_W-1:0];
    endfunction

    function automatic point_t predict_point(input logic [INDEX_W-1:0] idx);
        logic [63:0] n, i, phase, m, d;
        longint      x, y, z, dx, dy, re, im;
        logic        clip;
        point_t      p;
        i = 64'(idx);
        n = 64'(count_q);
        if (n == 0) n = 1;
        if (n > POINT_LIMIT) n = POINT_LIMIT;
        phase = (((i << 32) + (n >> 1)) / n) & 64'hFFFFFFFF;
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'(phase[29:0]);
        for (int k = 0; k < ROTATIONS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[k]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[k]);
            end
        end
        // fold the first-quadrant rotation into the selected quadrant
        case (phase[31:30])
            2'd0: begin re = x;  im = y;  end
            2'd1: begin re = -y; im = x;  end
            2'd2: begin re = -x; im = -y; end
            default: begin re = y; im = -x; end
        endcase
        if (mode_q == MODE_SPIRAL) begin
            m = (64'(radius_q) + ((i + 1) >> 1)) / (i + 1);
        end else if (mode_q == MODE_INVERSE) begin
            d = (radius_q == 0) ? 64'd1 : 64'(radius_q);
            m = (((i + 1) << 32) + (d >> 1)) / d;
        end else begin
            m = 64'(radius_q);
        end
        clip = 1'b0;
        p.re_part = scale_component(m, re, clip);
        p.im_part = scale_component(m, im, clip);
        p.clipped = clip;
        return p;
    endfunction

    // Track register writes, queue predictions on accepted requests and
    // check every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS: radius_q <= i_cfg_data;
                    CFG_COUNT:  count_q  <= i_cfg_data[COUNT_W-1:0];
                    CFG_MODE:   mode_q   <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                want = predict_point(i_point_index);
                if (typed_has_re) want.re_part = typed_re;
                if (typed_has_clip) want.clipped = typed_clip;
                pending_points.push_back(want);
            end
            if (o_valid) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("point with no request waiting");
                end else begin
                    want = pending_points.pop_front();
                    if (o_real_part !== want.re_part)
                        report_mismatch($sformatf("real %h, want %h",
                                                  o_real_part, want.re_part));
                    if (o_imag_part !== want.im_part)
                        report_mismatch($sformatf("imag %h, want %h",
                                                  o_imag_part, want.im_part));
                    if (o_saturated !== want.clipped)
                        report_mismatch($sformatf("saturated %b, want %b",
                                                  o_saturated, want.clipped));
                end
            end
        end
    end

    // Drop start and hold until every requested point has come back.
    task automatic drain_points();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx,
                                  input logic [RADIUS_W-1:0] value);
        drain_points();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Optionally idle first (gap sets how long), then hold start until the beat is taken.
    task automatic request_point(input logic [INDEX_W-1:0] idx, input int gap,
                                 input logic has_re, input logic [PART_W-1:0] re,
                                 input logic has_clip, input logic clip);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_point_index  <= idx;
        typed_has_re   <= has_re;
        typed_re       <= re;
        typed_has_clip <= has_clip;
        typed_clip     <= clip;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        #3ms;
        $display("FAIL scaled_root_of_unity_gen_top");
        $finish;
    end

    initial begin
        int          n_eff;
        int          gap;
        logic        no_idle;
        logic [23:0] rad;
        logic [6:0]  cnt;
        logic [5:0]  idx;

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
                write_register(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
            else
                request_point(DIRECTED_ROWS[r].value[INDEX_W-1:0],
                              $urandom_range(0, 4),
                              DIRECTED_ROWS[r].has_re, DIRECTED_ROWS[r].re_part,
                              DIRECTED_ROWS[r].has_clip, DIRECTED_ROWS[r].clipped);
        end

        // Random phases: new settings each phase, extremes first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin rad = 24'hFFFFFF; cnt = 7'd64; end
                1: begin rad = 24'd1;      cnt = 7'd1;  end
                default: begin
                    rad = ($urandom_range(0, 1) == 1) ? 24'($urandom)
                                                      : 24'($urandom_range(1, 24'h40000));
                    cnt = 7'($urandom_range(0, 127));
                end
            endcase
            write_register(CFG_RADIUS, rad);
            write_register(CFG_COUNT, {17'd0, cnt});
            write_register(CFG_MODE, (ph == 0) ? {22'd0, MODE_INVERSE} :
                                     (ph == 1) ? {22'd0, MODE_SPIRAL}  :
                                                 24'($urandom_range(0, 3)));
            if (ph % 3 == 2) write_register(2'd3, 24'($urandom));

            n_eff = (cnt == 0) ? 1 : ((cnt > POINT_LIMIT) ? POINT_LIMIT : cnt);
            // every third phase runs back to back with no idling
            no_idle = (ph % 3 == 0);
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 4) != 0)
                    idx = 6'($urandom_range(0, n_eff - 1));
                else
                    idx = 6'($urandom);
                gap = no_idle ? 0 : $urandom_range(0, 4);
                request_point(idx, gap, 1'b0, '0, 1'b0, 1'b0);
            end
        end

        drain_points();
        // Watch for stray beats past the pipeline depth
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS scaled_root_of_unity_gen_top");
        else
            $display("FAIL scaled_root_of_unity_gen_top");
        $finish;
    end

endmodule
